// ===== rtl/bcm_pkg.sv =====
package bcm_pkg;

    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int LEVEL_W    = 4;
    localparam int DELTA_W    = 8;
    localparam int CODE_W     = 8;
    localparam int WT_W       = 2;
    localparam int TICK_W     = 3;
    localparam int NUM_PLANES = 4;
    localparam int SUM_W      = 10;

    localparam logic [CODE_W-1:0]  ROW0_CODE   = 8'd160;
    localparam logic [CODE_W-1:0]  LOW_ROW_LIM = 8'd16;
    localparam logic [CODE_W-1:0]  HIGH_BASE   = 8'd15;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd15;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_CHANGE = 2'd1,
        OP_TICK   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PX_RD,
        ST_PX_WR,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    function automatic logic [CODE_W-1:0] row_code(input logic [ROW_W-1:0] row);
        logic [CODE_W-1:0] r8;
        logic [CODE_W-1:0] d;
        r8 = {{(CODE_W-ROW_W){1'b0}}, row};
        d  = r8 - HIGH_BASE;
        if (row == '0) begin
            return ROW0_CODE;
        end else if (r8 < LOW_ROW_LIM) begin
            return r8;
        end else begin
            return d << 4;
        end
    endfunction

endpackage

// ===== rtl/bitplane_led_matrix_scanner_top.sv =====
// Pixel item (set or change): busy through a read state and then a write state after the accepting edge;
// an out-of-range pixel, a zero change or an unused op is taken without going busy.
// Tick item: busy while the scan state reads the NUM_ROWS rows; row results appear one per cycle,
// the first one driven by the strobe register once the state register has entered the scan state.
// The rate is set by the single frame memory port, which reads one row per cycle.
// Reset (synchronous, active low) clears the sequencer, tick counter and row valid bits.
module bitplane_led_matrix_scanner_top import bcm_pkg::*; #(
    parameter int NUM_ROWS = 25,
    parameter int NUM_COLS = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_op,
    input  logic [COL_W-1:0]     i_pixel_col,
    input  logic [ROW_W-1:0]     i_pixel_row,
    input  logic [LEVEL_W-1:0]   i_level,
    input  logic [DELTA_W-1:0]   i_delta,
    output logic                 o_strobe,
    output logic [ROW_W-1:0]     o_row_index,
    output logic [CODE_W-1:0]    o_row_code,
    output logic [NUM_COLS-1:0]  o_row_bits,
    output logic [WT_W-1:0]      o_plane_weight,
    output logic                 o_last
);

    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

    t_mem_ctl                        ctl;
    logic [RW-1:0]                   addr;
    logic [CW-1:0]                   col;
    logic                            is_set;
    logic [LEVEL_W-1:0]              level;
    logic [DELTA_W-1:0]              delta;
    logic [NUM_PLANES*NUM_COLS-1:0]  rd_data;
    logic [NUM_PLANES*NUM_COLS-1:0]  wr_data;

    bcm_seq #(
        .NUM_ROWS(NUM_ROWS),
        .NUM_COLS(NUM_COLS),
        .RW(RW),
        .CW(CW)
    ) u_seq (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_pixel_col(i_pixel_col),
        .i_pixel_row(i_pixel_row),
        .i_level(i_level),
        .i_delta(i_delta),
        .o_ctl(ctl),
        .o_addr(addr),
        .o_col(col),
        .o_is_set(is_set),
        .o_level(level),
        .o_delta(delta),
        .o_strobe(o_strobe),
        .o_row_index(o_row_index),
        .o_weight(o_plane_weight),
        .o_last(o_last)
    );

    bcm_frame_mem #(
        .NUM_ROWS(NUM_ROWS),
        .NUM_COLS(NUM_COLS),
        .RW(RW)
    ) u_mem (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl(ctl),
        .i_addr(addr),
        .i_wr_data(wr_data),
        .o_rd_data(rd_data)
    );

    bcm_pixel_alu #(
        .NUM_COLS(NUM_COLS),
        .CW(CW)
    ) u_alu (
        .i_row_word(rd_data),
        .i_col(col),
        .i_is_set(is_set),
        .i_level(level),
        .i_delta(delta),
        .o_row_word(wr_data)
    );

    assign o_row_code = row_code(o_row_index);
    assign o_row_bits = rd_data[int'(o_plane_weight)*NUM_COLS +: NUM_COLS];

endmodule

// ===== rtl/bcm_frame_mem.sv =====
module bcm_frame_mem import bcm_pkg::*; #(
    parameter int NUM_ROWS = 25,
    parameter int NUM_COLS = 25,
    parameter int RW       = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_mem_ctl                         i_ctl,
    input  logic [RW-1:0]                    i_addr,
    input  logic [NUM_PLANES*NUM_COLS-1:0]   i_wr_data,
    output logic [NUM_PLANES*NUM_COLS-1:0]   o_rd_data
);

    logic [NUM_PLANES*NUM_COLS-1:0] mem [NUM_ROWS];
    logic [NUM_PLANES*NUM_COLS-1:0] r_rd_data;
    logic [NUM_ROWS-1:0]            r_valid;
    logic                           r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_valid[i_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/bcm_pixel_alu.sv =====
module bcm_pixel_alu import bcm_pkg::*; #(
    parameter int NUM_COLS = 25,
    parameter int CW       = 5
) (
    input  logic [NUM_PLANES*NUM_COLS-1:0] i_row_word,
    input  logic [CW-1:0]                  i_col,
    input  logic                           i_is_set,
    input  logic [LEVEL_W-1:0]             i_level,
    input  logic [DELTA_W-1:0]             i_delta,
    output logic [NUM_PLANES*NUM_COLS-1:0] o_row_word
);

    logic [LEVEL_W-1:0] cur_lvl;
    logic [LEVEL_W-1:0] new_lvl;
    logic [SUM_W-1:0]   sum;

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            cur_lvl[p] = i_row_word[p*NUM_COLS + int'(i_col)];
        end
        sum = {{(SUM_W-LEVEL_W){1'b0}}, cur_lvl}
            + {{(SUM_W-DELTA_W){i_delta[DELTA_W-1]}}, i_delta};
        if (i_is_set) begin
            new_lvl = i_level;
        end else if (sum[SUM_W-1]) begin
            new_lvl = '0;
        end else if (sum > SUM_W'(LEVEL_MAX)) begin
            new_lvl = LEVEL_MAX;
        end else begin
            new_lvl = sum[LEVEL_W-1:0];
        end
        o_row_word = i_row_word;
        for (int p = 0; p < NUM_PLANES; p++) begin
            o_row_word[p*NUM_COLS + int'(i_col)] = new_lvl[p];
        end
    end

endmodule

// ===== rtl/bcm_seq.sv =====
module bcm_seq import bcm_pkg::*; #(
    parameter int NUM_ROWS = 25,
    parameter int NUM_COLS = 25,
    parameter int RW       = 5,
    parameter int CW       = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_op,
    input  logic [COL_W-1:0]    i_pixel_col,
    input  logic [ROW_W-1:0]    i_pixel_row,
    input  logic [LEVEL_W-1:0]  i_level,
    input  logic [DELTA_W-1:0]  i_delta,
    output t_mem_ctl            o_ctl,
    output logic [RW-1:0]       o_addr,
    output logic [CW-1:0]       o_col,
    output logic                o_is_set,
    output logic [LEVEL_W-1:0]  o_level,
    output logic [DELTA_W-1:0]  o_delta,
    output logic                o_strobe,
    output logic [ROW_W-1:0]    o_row_index,
    output logic [WT_W-1:0]     o_weight,
    output logic                o_last
);

    localparam logic [ROW_W:0] COL_LIM  = (ROW_W+1)'(NUM_COLS);
    localparam logic [ROW_W:0] ROW_LIM  = (ROW_W+1)'(NUM_ROWS);
    localparam logic [RW-1:0]  LAST_ROW = RW'(NUM_ROWS - 1);

    t_state              r_state, n_state;
    logic                accept;
    logic                in_range;
    logic                px_go;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [WT_W-1:0]     r_weight, n_weight;
    logic [RW-1:0]       r_scan;
    logic                r_strobe;
    logic [ROW_W-1:0]    r_out_row;
    logic                r_last;
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic                r_is_set;
    logic [LEVEL_W-1:0]  r_level;
    logic [DELTA_W-1:0]  r_delta;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({1'b0, i_pixel_col} < COL_LIM) && ({1'b0, i_pixel_row} < ROW_LIM);
    assign px_go    = in_range
                   && ((i_op == OP_SET) || ((i_op == OP_CHANGE) && (i_delta != '0)));

    always_comb begin
        n_tick = r_tick + TICK_W'(1);
        if (n_tick[0]) begin
            n_weight = 2'd3;
        end else if (n_tick[1]) begin
            n_weight = 2'd2;
        end else if (n_tick[2]) begin
            n_weight = 2'd1;
        end else begin
            n_weight = 2'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_TICK) begin
                        n_state = ST_SCAN;
                    end else if (px_go) begin
                        n_state = ST_PX_RD;
                    end
                end
            end
            ST_PX_RD: n_state = ST_PX_WR;
            ST_PX_WR: n_state = ST_IDLE;
            ST_SCAN: begin
                if (r_scan == LAST_ROW) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl  = '0;
        o_addr = r_row;
        unique case (r_state)
            ST_PX_RD: o_ctl.rd_en = 1'b1;
            ST_PX_WR: o_ctl.wr_en = 1'b1;
            ST_SCAN: begin
                o_ctl.rd_en = 1'b1;
                o_addr      = r_scan;
            end
            default: o_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tick   <= '0;
            r_weight <= '0;
            r_scan   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_SCAN);
            if (accept && (i_op == OP_TICK)) begin
                r_tick   <= n_tick;
                r_weight <= n_weight;
                r_scan   <= '0;
            end else if (r_state == ST_SCAN) begin
                r_scan <= r_scan + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row <= ROW_W'(r_scan);
        r_last    <= (r_scan == LAST_ROW);
        if (accept) begin
            r_col    <= i_pixel_col[CW-1:0];
            r_row    <= i_pixel_row[RW-1:0];
            r_is_set <= (i_op == OP_SET);
            r_level  <= i_level;
            r_delta  <= i_delta;
        end
    end

    assign o_col       = r_col;
    assign o_is_set    = r_is_set;
    assign o_level     = r_level;
    assign o_delta     = r_delta;
    assign o_strobe    = r_strobe;
    assign o_row_index = r_out_row;
    assign o_weight    = r_weight;
    assign o_last      = r_strobe && r_last;

endmodule

// ===== rtl/bcm_checker.sv =====
module bcm_checker import bcm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 busy,
    input logic                 o_strobe,
    input logic [ROW_W-1:0]     o_row_index,
    input logic [WT_W-1:0]      o_plane_weight,
    input logic                 o_last
);

    a_last_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last without strobe");

    a_rows_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && (o_row_index == $past(o_row_index) + 5'd1))
        else $error("scan rows not consecutive");

    a_scan_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> (o_row_index == '0))
        else $error("scan did not start at row zero");

    a_weight_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> $stable(o_plane_weight))
        else $error("plane weight changed during scan");

    a_busy_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("not busy during scan");

endmodule

bind bitplane_led_matrix_scanner_top bcm_checker u_bcm_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .busy(busy),
    .o_strobe(o_strobe),
    .o_row_index(o_row_index),
    .o_plane_weight(o_plane_weight),
    .o_last(o_last)
);

// ===== tb/sv/bitplane_led_matrix_scanner_top_tb.sv =====
`timescale 1ns / 1ps

module bitplane_led_matrix_scanner_top_tb;
    import bcm_pkg::*;

    localparam int NUM_ROWS = 25;
    localparam int NUM_COLS = 25;
    localparam int RANDOM_CMDS = 480;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] level;
        logic [DELTA_W-1:0] delta;
    } pixel_cmd_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row_index;
        logic [CODE_W-1:0]   row_code;
        logic [NUM_COLS-1:0] row_bits;
        logic [WT_W-1:0]     plane_weight;
        logic                last;
    } row_scan_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_op = '0;
    logic [COL_W-1:0]    i_pixel_col = '0;
    logic [ROW_W-1:0]    i_pixel_row = '0;
    logic [LEVEL_W-1:0]  i_level = '0;
    logic [DELTA_W-1:0]  i_delta = '0;
    logic                o_strobe;
    logic [ROW_W-1:0]    o_row_index;
    logic [CODE_W-1:0]   o_row_code;
    logic [NUM_COLS-1:0] o_row_bits;
    logic [WT_W-1:0]     o_plane_weight;
    logic                o_last;

    pixel_cmd_t  cmds_pending[$];
    row_scan_t   scans_due[$];
    pixel_cmd_t  offered;

    logic [LEVEL_W-1:0] frame_level[NUM_ROWS][NUM_COLS];
    logic [TICK_W-1:0]  tick_count = '0;

    int          n_accepted = 0;
    int          n_errors = 0;
    int          n_set = 0;
    int          n_change = 0;
    int          n_tick = 0;
    int          n_ignored = 0;
    int          n_rows_checked = 0;
    int unsigned cycle_count = 0;

    bitplane_led_matrix_scanner_top #(
        .NUM_ROWS(NUM_ROWS),
        .NUM_COLS(NUM_COLS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_pixel_col(i_pixel_col),
        .i_pixel_row(i_pixel_row),
        .i_level(i_level),
        .i_delta(i_delta),
        .o_strobe(o_strobe),
        .o_row_index(o_row_index),
        .o_row_code(o_row_code),
        .o_row_bits(o_row_bits),
        .o_plane_weight(o_plane_weight),
        .o_last(o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [CODE_W-1:0] expected_row_code(input int r);
        if (r == 0) begin
            return 8'd160;
        end else if (r < 16) begin
            return CODE_W'(r);
        end else begin
            return CODE_W'((r - 15) << 4);
        end
    endfunction

    task automatic apply_to_frame(input pixel_cmd_t c);
        int        sum;
        int        w;
        row_scan_t s;
        if (c.op == OP_SET || c.op == OP_CHANGE) begin
            if (c.col >= NUM_COLS || c.row >= NUM_ROWS) begin
                n_ignored++;
            end else if (c.op == OP_SET) begin
                frame_level[c.row][c.col] = c.level;
                n_set++;
            end else begin
                n_change++;
                if (c.delta != '0) begin
                    sum = int'(frame_level[c.row][c.col]);
                    sum = sum + int'($signed(c.delta));
                    if (sum < 0) sum = 0;
                    if (sum > 15) sum = 15;
                    frame_level[c.row][c.col] = LEVEL_W'(sum);
                end
            end
        end else if (c.op == OP_TICK) begin
            n_tick++;
            tick_count = tick_count + 1'b1;
            if (tick_count[0]) w = 3;
            else if (tick_count[1]) w = 2;
            else if (tick_count[2]) w = 1;
            else w = 0;
            for (int r = 0; r < NUM_ROWS; r++) begin
                s.row_index    = ROW_W'(r);
                s.row_code     = expected_row_code(r);
                for (int k = 0; k < NUM_COLS; k++) begin
                    s.row_bits[k] = frame_level[r][k][w];
                end
                s.plane_weight = WT_W'(w);
                s.last         = (r == NUM_ROWS - 1);
                scans_due.push_back(s);
            end
        end else begin
            n_ignored++;
        end
    endtask

    task automatic drive_fields(input pixel_cmd_t c);
        i_op        <= c.op;
        i_pixel_col <= c.col;
        i_pixel_row <= c.row;
        i_level     <= c.level;
        i_delta     <= c.delta;
    endtask

    task automatic queue_cmd(input logic [1:0] op, input int col, input int row,
                             input int level, input int delta);
        pixel_cmd_t c;
        c.op    = op;
        c.col   = COL_W'(col);
        c.row   = ROW_W'(row);
        c.level = LEVEL_W'(level);
        c.delta = DELTA_W'(delta);
        cmds_pending.push_back(c);
    endtask

    function automatic logic [4:0] pick_coord();
        if ($urandom_range(15) == 0) begin
            return 5'($urandom_range(31, 25));
        end
        return 5'($urandom_range(24));
    endfunction

    function automatic pixel_cmd_t random_cmd();
        pixel_cmd_t c;
        int         kind;
        int         sel;
        c = pixel_cmd_t'($urandom);
        kind = $urandom_range(99);
        sel = $urandom_range(7);
        c.col = pick_coord();
        c.row = pick_coord();
        if (kind < 36) begin
            c.op = OP_SET;
        end else if (kind < 68) begin
            c.op = OP_CHANGE;
            if (sel == 0) c.delta = '0;
            else if (sel > 2) c.delta = DELTA_W'(int'($urandom_range(16)) - 8);
        end else if (kind < 94) begin
            c.op = OP_TICK;
        end else begin
            c.op = OP_UNUSED;
        end
        return c;
    endfunction

    // offer the next item once the current one is taken, with random gaps
    always @(posedge i_clk) begin
        int gap_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_to_frame(offered);
                n_accepted++;
            end
            if (!start || !busy) begin
                gap_pct = (n_accepted >= 150 && n_accepted < 300) ? 0 : 19;
                if (cmds_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    offered = cmds_pending.pop_front();
                    drive_fields(offered);
                    start <= 1'b1;
                end else begin
                    drive_fields(pixel_cmd_t'($urandom));
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        row_scan_t e;
        if (i_rst_n && o_strobe) begin
            if (scans_due.size() == 0) begin
                $error("row result with none expected: row_index %0d", o_row_index);
                n_errors++;
            end else begin
                e = scans_due.pop_front();
                n_rows_checked++;
                check_field("row_index", e.row_index, o_row_index);
                check_field("row_code", e.row_code, o_row_code);
                check_field("row_bits", e.row_bits, o_row_bits);
                check_field("plane_weight", e.plane_weight, o_plane_weight);
                check_field("last", e.last, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitplane_led_matrix_scanner_top_tb: errors");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int k = 0; k < NUM_COLS; k++) begin
                frame_level[r][k] = '0;
            end
        end

        queue_cmd(OP_SET, 0, 0, 15, 0);
        queue_cmd(OP_SET, 24, 24, 15, 0);
        queue_cmd(OP_SET, 24, 0, 10, 0);
        queue_cmd(OP_SET, 0, 24, 5, 0);
        queue_cmd(OP_SET, 25, 3, 15, 0);
        queue_cmd(OP_SET, 3, 31, 15, 0);
        queue_cmd(OP_SET, 31, 31, 7, 8'hFF);
        queue_cmd(OP_CHANGE, 0, 0, 0, 127);
        queue_cmd(OP_CHANGE, 24, 0, 15, 127);
        queue_cmd(OP_CHANGE, 0, 24, 0, -128);
        queue_cmd(OP_CHANGE, 24, 24, 3, 0);
        queue_cmd(OP_CHANGE, 12, 12, 0, -1);
        queue_cmd(OP_CHANGE, 12, 12, 0, 6);
        queue_cmd(OP_CHANGE, 30, 12, 0, 5);
        queue_cmd(OP_UNUSED, 31, 31, 15, 8'hFF);
        queue_cmd(OP_SET, 16, 17, 9, 0);
        queue_cmd(OP_CHANGE, 16, 17, 0, -1);
        repeat (8) queue_cmd(OP_TICK, 31, 31, 15, 8'hFF);
        repeat (RANDOM_CMDS) cmds_pending.push_back(random_cmd());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_pending.size() != 0 || start) @(posedge i_clk);
        while (scans_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("items: %0d set, %0d change, %0d refresh, %0d ignored",
                 n_set, n_change, n_tick, n_ignored);
        $display("row results checked: %0d", n_rows_checked);
        if (n_errors == 0) begin
            $display("bitplane_led_matrix_scanner_top_tb: clean");
        end else begin
            $display("bitplane_led_matrix_scanner_top_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bcm_pkg.sv
rtl/bcm_frame_mem.sv
rtl/bcm_pixel_alu.sv
rtl/bcm_seq.sv
rtl/bitplane_led_matrix_scanner_top.sv
rtl/bcm_checker.sv
tb/sv/bitplane_led_matrix_scanner_top_tb.sv
